/* hdl/hrtq_pkg.sv */
package hrtq_pkg;

  typedef enum logic [2:0] {
    ACT_PASS    = 3'd0,
    ACT_SWALLOW = 3'd1,
    ACT_TAP     = 3'd2,
    ACT_REG     = 3'd3,
    ACT_UNREG   = 3'd4
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [2:0] slot;
    logic       last;
  } result_t;

  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_t;

  localparam logic [2:0]  NUMBER_SLOTS = 3'd3;
  localparam logic [15:0] TERM_RESET   = 16'd200;

endpackage

/* hdl/hrtq_cmp.sv */
module hrtq_cmp import hrtq_pkg::*; #(
  parameter int TIME_BITS = 16
) (
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] ptime_i,
  input  logic [15:0]          term_i,
  output cmp_t                 cmp_o
);

  localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;

  logic [TIME_BITS-1:0] elapsed;
  logic [CW-1:0]        elapsed_ext;
  logic [CW-1:0]        term_ext;

  // elapsed time wraps modulo 2^TIME_BITS
  assign elapsed     = now_i - ptime_i;
  assign elapsed_ext = CW'(elapsed);
  assign term_ext    = CW'(term_i);

  assign cmp_o.lt = elapsed_ext < term_ext;
  assign cmp_o.gt = elapsed_ext > term_ext;

endmodule

/* hdl/hrtq_ctrl.sv */
module hrtq_ctrl import hrtq_pkg::*; #(
  parameter int SLOT_COUNT = 6,
  parameter int TIME_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           key_slot_i,
  input  logic                 pressed_i,
  input  logic [15:0]          now_ms_i,
  input  logic                 number_layer_on_i,
  input  logic                 symbol_layer_on_i,
  input  logic                 out_free_i,
  input  cmp_t                 cmp_i,
  output logic [TIME_BITS-1:0] now_o,
  output logic [TIME_BITS-1:0] ptime_o,
  output logic                 emit_o,
  output result_t              res_o
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int NW = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SLOT  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic [SLOT_COUNT-1:0] held_q, held_d;
  result_t               fin_q, fin_d;
  logic [2:0]            key_q;
  logic                  press_q;
  logic [TIME_BITS-1:0]  now_q;
  logic                  num_q;
  logic                  sym_q;
  logic [TIME_BITS-1:0]  ptime_q [SLOT_COUNT];

  logic          accept;
  logic          in_is_slot;
  logic          armed;
  logic          promote;
  logic          pt_we;
  logic [2:0]    slot_code;
  logic [NW-1:0] now_ext;

  assign accept     = in_valid_i && in_ready_o;
  assign in_is_slot = 32'(key_slot_i) < 32'(SLOT_COUNT);
  assign armed      = (key_q < NUMBER_SLOTS) ? num_q : sym_q;
  assign promote    = active_q[idx_q] && (press_q || cmp_i.gt);
  assign slot_code  = 3'(idx_q);
  assign now_ext    = NW'(now_ms_i);

  assign now_o   = now_q;
  assign ptime_o = ptime_q[idx_q];

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    active_d   = active_q;
    held_d     = held_q;
    fin_d      = fin_q;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    res_o      = '{ACT_PASS, 3'd0, 1'b0};
    pt_we      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d   = in_is_slot ? IW'(key_slot_i) : '0;
          state_d = in_is_slot ? ST_SLOT : ST_SCAN;
        end
      end
      ST_SLOT: begin
        if (out_free_i) begin
          emit_o = 1'b1;
          if (armed && press_q) begin
            pt_we           = 1'b1;
            active_d[idx_q] = 1'b1;
            held_d[idx_q]   = 1'b0;
            res_o           = '{ACT_SWALLOW, slot_code, 1'b1};
            state_d         = ST_IDLE;
          end else if (active_q[idx_q]) begin
            active_d[idx_q] = 1'b0;
            if (cmp_i.lt) begin
              res_o   = '{ACT_TAP, slot_code, 1'b0};
              fin_d   = '{ACT_SWALLOW, slot_code, 1'b1};
              state_d = ST_FINAL;
            end else begin
              res_o   = '{ACT_SWALLOW, slot_code, 1'b1};
              state_d = ST_IDLE;
            end
          end else if (held_q[idx_q]) begin
            held_d[idx_q] = 1'b0;
            res_o         = '{ACT_UNREG, slot_code, 1'b0};
            fin_d         = '{ACT_SWALLOW, slot_code, 1'b1};
            state_d       = ST_FINAL;
          end else begin
            res_o   = '{ACT_PASS, slot_code, 1'b1};
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (!promote || out_free_i) begin
          if (promote) begin
            emit_o          = 1'b1;
            active_d[idx_q] = 1'b0;
            held_d[idx_q]   = 1'b1;
            res_o           = '{ACT_REG, slot_code, 1'b0};
          end
          if (idx_q == LAST_IDX) begin
            fin_d   = '{ACT_PASS, 3'd0, 1'b1};
            state_d = ST_FINAL;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_FINAL: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          res_o   = fin_q;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      active_q <= '0;
      held_q   <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      active_q <= active_d;
      held_q   <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
    if (accept) begin
      key_q   <= key_slot_i;
      press_q <= pressed_i;
      now_q   <= now_ext[TIME_BITS-1:0];
      num_q   <= number_layer_on_i;
      sym_q   <= symbol_layer_on_i;
    end
    if (pt_we) begin
      ptime_q[idx_q] <= now_q;
    end
  end

endmodule

/* hdl/home_row_tap_hold_qualifier.sv */
// Sequencing: a dual-role key event goes from idle to the slot state, which writes
//   its first result out once the output is free; any other key emits promotions
//   during the scan and its pass-through from the final state; input waits for idle.
// Flow: a dual-role key event visits idle, slot and, for a tap or a held-slot
//   release, final; any other key visits idle, the scan with one slot visited per
//   cycle by the shared elapsed-time compare unit, plus output stalls, and final.
// Reset: slot flags and control clear at once, the tap threshold returns to 200.
module home_row_tap_hold_qualifier import hrtq_pkg::*; #(
  parameter int SLOT_COUNT = 6,
  parameter int TIME_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  key_slot_i,
  input  logic        pressed_i,
  input  logic [15:0] now_ms_i,
  input  logic        number_layer_on_i,
  input  logic        symbol_layer_on_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [2:0]  slot_o,
  output logic        last_o
);

  logic [15:0]          term_q;
  logic                 out_valid_q;
  result_t              out_q;
  logic                 out_free;
  logic                 emit;
  result_t              res;
  cmp_t                 cmp;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] ptime;

  assign out_free = !out_valid_q || out_ready_i;

  hrtq_ctrl #(
    .SLOT_COUNT(SLOT_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .key_slot_i       (key_slot_i),
    .pressed_i        (pressed_i),
    .now_ms_i         (now_ms_i),
    .number_layer_on_i(number_layer_on_i),
    .symbol_layer_on_i(symbol_layer_on_i),
    .out_free_i       (out_free),
    .cmp_i            (cmp),
    .now_o            (now_t),
    .ptime_o          (ptime),
    .emit_o           (emit),
    .res_o            (res)
  );

  hrtq_cmp #(
    .TIME_BITS(TIME_BITS)
  ) u_cmp (
    .now_i  (now_t),
    .ptime_i(ptime),
    .term_i (term_q),
    .cmp_o  (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q      <= TERM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        term_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = out_q.action;
  assign slot_o      = out_q.slot;
  assign last_o      = out_q.last;

endmodule
